### sv/blk2b_pkg.sv
package blk2b_pkg;

    localparam int RND_W  = 4;

    localparam logic [2:0] REG_DIGEST_LEN  = 3'd0;
    localparam logic [2:0] REG_KEY_LEN     = 3'd1;
    localparam logic [2:0] REG_SALT_LOW    = 3'd2;
    localparam logic [2:0] REG_SALT_HIGH   = 3'd3;
    localparam logic [2:0] REG_PERSON_LOW  = 3'd4;
    localparam logic [2:0] REG_PERSON_HIGH = 3'd5;

    typedef enum logic [2:0] {
        S_LOAD,
        S_IDLE,
        S_DECIDE,
        S_FIN,
        S_RND,
        S_DONE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             load;
        logic             latch;
        logic             store;
        logic             init;
        logic             init_final;
        logic             g_en;
        logic             g_half;
        logic             g_diag;
        logic [RND_W-1:0] round;
        logic             finish;
        logic             out_adv;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic out_last;
    } stat_t;

    function automatic logic [63:0] iv_word(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'h6A09E667F3BCC908;
            3'd1: r = 64'hBB67AE8584CAA73B;
            3'd2: r = 64'h3C6EF372FE94F82B;
            3'd3: r = 64'hA54FF53A5F1D36F1;
            3'd4: r = 64'h510E527FADE682D1;
            3'd5: r = 64'h9B05688C2B3E6C1F;
            3'd6: r = 64'h1F83D9ABFB41BD6B;
            default: r = 64'h5BE0CD19137E2179;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] j);
        logic [63:0] row;
        case (r)
            4'd1: row = 64'hEA489FD61C02B753;
            4'd2: row = 64'hB8C052FDAE367194;
            4'd3: row = 64'h7931DCBE265A40F8;
            4'd4: row = 64'h905724AFE1BC683D;
            4'd5: row = 64'h2C6A0B834D75FE19;
            4'd6: row = 64'hC51FED4A0763928B;
            4'd7: row = 64'hDB7EC13950F4862A;
            4'd8: row = 64'h6FE9B308C2D714A5;
            4'd9: row = 64'hA2847615FB9E3CD0;
            default: row = 64'h0123456789ABCDEF;
        endcase
        return row[63 - 4 * j -: 4];
    endfunction

endpackage

### sv/blk2b_ctrl.sv
module blk2b_ctrl
    import blk2b_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  in_last,
    input  logic  in_nonzero,
    input  logic  cfg_valid,
    output logic  cfg_ready,
    input  logic  cfg_known,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic             pre_reg, pre_next;
    logic             last_reg, last_next;
    logic             store_reg, store_next;
    logic             fin_reg, fin_next;
    logic [1:0]       step_reg, step_next;
    logic [RND_W-1:0] round_reg, round_next;
    logic             round_end;

    assign round_end = (step_reg == 2'd3) && (round_reg == RND_W'(ROUNDS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            pre_reg   <= 1'b0;
            last_reg  <= 1'b0;
            store_reg <= 1'b0;
            fin_reg   <= 1'b0;
            step_reg  <= '0;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            pre_reg   <= pre_next;
            last_reg  <= last_next;
            store_reg <= store_next;
            fin_reg   <= fin_next;
            step_reg  <= step_next;
            round_reg <= round_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pre_next   = pre_reg;
        last_next  = last_reg;
        store_next = store_reg;
        fin_next   = fin_reg;
        step_next  = step_reg;
        round_next = round_reg;
        unique case (state_reg)
            S_LOAD: state_next = S_IDLE;
            S_IDLE: begin
                if (cfg_valid) begin
                    if (cfg_known) state_next = S_LOAD;
                end else if (s_tvalid && (in_nonzero || in_last)) begin
                    pre_next   = in_nonzero && stat.pending;
                    last_next  = in_last;
                    store_next = in_nonzero;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (pre_reg) begin
                    pre_next   = 1'b0;
                    fin_next   = 1'b0;
                    step_next  = '0;
                    round_next = '0;
                    state_next = S_RND;
                end else if (last_reg) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FIN: begin
                fin_next   = 1'b1;
                step_next  = '0;
                round_next = '0;
                state_next = S_RND;
            end
            S_RND: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) round_next = round_reg + RND_W'(1);
                if (round_end) state_next = S_DONE;
            end
            S_DONE: state_next = fin_reg ? S_OUT : S_DECIDE;
            S_OUT: begin
                if (m_tready && stat.out_last) state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        m_tvalid   = 1'b0;
        cmd.g_half = step_reg[0];
        cmd.g_diag = step_reg[1];
        cmd.round  = round_reg;
        unique case (state_reg)
            S_LOAD: cmd.load = 1'b1;
            S_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                cmd.latch = s_tvalid && !cfg_valid;
            end
            S_DECIDE: begin
                cmd.init  = pre_reg;
                cmd.store = !pre_reg && store_reg;
            end
            S_FIN: begin
                cmd.init       = 1'b1;
                cmd.init_final = 1'b1;
            end
            S_RND:  cmd.g_en   = 1'b1;
            S_DONE: cmd.finish = 1'b1;
            S_OUT: begin
                m_tvalid    = 1'b1;
                cmd.out_adv = m_tready;
            end
            default: cmd = '0;
        endcase
    end

endmodule

### sv/blk2b_dp.sv
module blk2b_dp
    import blk2b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [63:0] in_word,
    input  logic [3:0]  in_bc,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic [63:0] out_word,
    output logic [3:0]  out_bytes
);

    logic [6:0]  dlen_reg, klen_reg;
    logic [63:0] salt_lo_reg, salt_hi_reg, pers_lo_reg, pers_hi_reg;
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [16];
    logic [63:0] v_next [16];
    logic [63:0] buf_reg [16];
    logic [15:0] vld_reg;
    logic [3:0]  idx_reg;
    logic        pend_reg;
    logic [63:0] cnt_lo_reg, cnt_hi_reg;
    logic [63:0] w_reg;
    logic [3:0]  bc_reg;
    logic [2:0]  k_reg;
    logic [63:0] par [8];
    logic [63:0] masked;
    logic [64:0] lo_sum;
    logic [3:0]  rmod;
    logic [6:0]  nbytes;
    logic [3:0]  nwords;
    logic [6:0]  left;

    always_comb begin
        par[0] = {32'h0, 8'd1, 8'd1, 1'b0, klen_reg, 1'b0, dlen_reg};
        par[1] = '0;
        par[2] = '0;
        par[3] = '0;
        par[4] = salt_lo_reg;
        par[5] = salt_hi_reg;
        par[6] = pers_lo_reg;
        par[7] = pers_hi_reg;
    end

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            masked[8*j +: 8] = (4'(j) < bc_reg) ? w_reg[8*j +: 8] : 8'h00;
        end
    end

    assign lo_sum = {1'b0, cnt_lo_reg} + {61'h0, bc_reg};
    assign rmod   = (cmd.round >= 4'd10) ? cmd.round - 4'd10 : cmd.round;

    always_comb begin
        logic [3:0]  ia, ib, ic, id, sel;
        logic [63:0] a, b, c, d, x;
        for (int i = 0; i < 16; i++) v_next[i] = v_reg[i];
        for (int i = 0; i < 4; i++) begin
            ia  = 4'(i);
            ib  = cmd.g_diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
            ic  = cmd.g_diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
            id  = cmd.g_diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
            sel = sigma(rmod, {cmd.g_diag, 2'(i), cmd.g_half});
            x   = vld_reg[sel] ? buf_reg[sel] : 64'h0;
            a   = v_reg[ia] + v_reg[ib] + x;
            d   = v_reg[id] ^ a;
            d   = cmd.g_half ? {d[15:0], d[63:16]} : {d[31:0], d[63:32]};
            c   = v_reg[ic] + d;
            b   = v_reg[ib] ^ c;
            b   = cmd.g_half ? {b[62:0], b[63]} : {b[23:0], b[63:24]};
            v_next[ia] = a;
            v_next[ib] = b;
            v_next[ic] = c;
            v_next[id] = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dlen_reg    <= 7'd64;
            klen_reg    <= '0;
            salt_lo_reg <= '0;
            salt_hi_reg <= '0;
            pers_lo_reg <= '0;
            pers_hi_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIGEST_LEN:  dlen_reg    <= cfg_data[6:0];
                REG_KEY_LEN:     klen_reg    <= cfg_data[6:0];
                REG_SALT_LOW:    salt_lo_reg <= cfg_data;
                REG_SALT_HIGH:   salt_hi_reg <= cfg_data;
                REG_PERSON_LOW:  pers_lo_reg <= cfg_data;
                REG_PERSON_HIGH: pers_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            k_reg    <= '0;
        end else begin
            if (cmd.load || cmd.finish) begin
                vld_reg  <= '0;
                idx_reg  <= '0;
                pend_reg <= 1'b0;
                k_reg    <= '0;
            end else if (cmd.store) begin
                vld_reg[idx_reg] <= 1'b1;
                idx_reg          <= idx_reg + 4'd1;
                if (idx_reg == 4'd15) pend_reg <= 1'b1;
            end else if (cmd.out_adv) begin
                k_reg <= k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            w_reg  <= in_word;
            bc_reg <= (in_bc > 4'd8) ? 4'd8 : in_bc;
        end
        if (cmd.store) begin
            buf_reg[idx_reg] <= masked;
            cnt_lo_reg       <= lo_sum[63:0];
            cnt_hi_reg       <= cnt_hi_reg + {63'h0, lo_sum[64]};
        end
        if (cmd.load) begin
            cnt_lo_reg <= '0;
            cnt_hi_reg <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= iv_word(3'(i)) ^ par[i];
        end
        if (cmd.finish) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
        end
        if (cmd.init) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            for (int i = 0; i < 4; i++) v_reg[i + 8] <= iv_word(3'(i));
            v_reg[12] <= iv_word(3'd4) ^ cnt_lo_reg;
            v_reg[13] <= iv_word(3'd5) ^ cnt_hi_reg;
            v_reg[14] <= cmd.init_final ? ~iv_word(3'd6) : iv_word(3'd6);
            v_reg[15] <= iv_word(3'd7);
        end else if (cmd.g_en) begin
            for (int i = 0; i < 16; i++) v_reg[i] <= v_next[i];
        end
    end

    assign nbytes = (dlen_reg == 7'd0) ? 7'd1 : (dlen_reg > 7'd64) ? 7'd64 : dlen_reg;
    assign nwords = 4'((nbytes + 7'd7) >> 3);
    assign left   = nbytes - {1'b0, k_reg, 3'b000};

    always_comb begin
        out_bytes = (left > 7'd8) ? 4'd8 : left[3:0];
        for (int j = 0; j < 8; j++) begin
            out_word[8*j +: 8] = (4'(j) < out_bytes) ? h_reg[k_reg][8*j +: 8] : 8'h00;
        end
    end

    assign stat.pending  = pend_reg;
    assign stat.out_last = ({1'b0, k_reg} == nwords - 4'd1);

endmodule

### sv/blake2b_hash_core.sv
// BLAKE2b hash core, one 64-bit word per accepted input handshake.
// A word that starts no compression is latched (IDLE) and stored (DECIDE). A compression
// (init, 48 half-G steps of four shared G units, fold) runs 12 rounds of 4 steps; no new
// word is accepted until it ends. Final word: compression, one digest word per output
// handshake, chain reload. Reset (aresetn low, synchronous): config defaults, chain load.
module blake2b_hash_core
    import blk2b_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // data_word[63:0], byte_count[67:64], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // digest_word[63:0], digest_bytes[67:64], zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cmd_t        cmd;
    stat_t       stat;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;

    blk2b_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .in_last    (s_tlast),
        .in_nonzero (s_tdata[67:64] != 4'd0),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_known  (cfg_index <= REG_PERSON_HIGH),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .stat       (stat),
        .cmd        (cmd)
    );

    blk2b_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_tdata[63:0]),
        .in_bc     (s_tdata[67:64]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_word),
        .out_bytes (out_bytes)
    );

    assign m_tdata = {4'h0, out_bytes, out_word};
    assign m_tlast = stat.out_last;

endmodule
